// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DIFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/difp_pkg.sv =====
// ----------------------------------------------------------------------------
// difp_pkg
// types, register codes and constants of the delimited integer field parser
// ----------------------------------------------------------------------------
package difp_pkg;

    // field sizes
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 17;
    localparam int NUMBER_W = 8;

    // default digit limit per field
    localparam int MAX_DIGITS_DEF = 5;

    // character constants
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELDS = 2'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd36;
    localparam logic [BYTE_W-1:0] SEP_CHAR_RST   = 8'd44;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd42;
    localparam logic [BYTE_W-1:0] MAX_FIELDS_RST = 8'd5;

    // input item
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } text_item_t;

    // result item
    typedef struct packed {
        logic [VALUE_W-1:0]  field_value;
        logic [NUMBER_W-1:0] field_number;
        logic                too_long;
        logic                last_field;
    } field_item_t;

endpackage

// ===== sv/difp_stream_if.sv =====
// ----------------------------------------------------------------------------
// difp_stream_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
interface difp_stream_if #(
    parameter type payload_t = difp_pkg::text_item_t
);

    logic     valid;
    logic     ready;
    payload_t data;

    // producer side
    modport source (
        output valid,
        output data,
        input  ready
    );

    // consumer side
    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== sv/delimited_integer_field_parser.sv =====
// a result item is registered from the text byte that closes its field and appears in the next cycle
// throughput: one text byte per cycle, limited only by the single result register
// a byte is still taken while a result waits, as long as that result leaves the same cycle
// reset: asynchronous, active low; hunting for the start character, registers at defaults
// ----------------------------------------------------------------------------
// delimited_integer_field_parser
// scans a byte stream for framed, delimited decimal fields and emits
// one result item per field with its value, index and flags
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delimited_integer_field_parser #(
    parameter int MAX_DIGITS = difp_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [difp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [difp_pkg::BYTE_W-1:0]     cfg_data,
    difp_stream_if.sink                     text_in,
    difp_stream_if.source                   field_out
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int VW    = difp_pkg::VALUE_W;
    localparam int NW    = difp_pkg::NUMBER_W;
    localparam int BW    = difp_pkg::BYTE_W;

    // configuration registers
    logic [BW-1:0] start_char_reg;
    logic [BW-1:0] sep_char_reg;
    logic [BW-1:0] end_char_reg;
    logic [BW-1:0] max_fields_reg;

    // parser state
    logic             in_frame_reg,    in_frame_next;
    logic [VW-1:0]    acc_reg,         acc_next;
    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    logic             overlong_reg,    overlong_next;
    logic [NW-1:0]    fields_done_reg, fields_done_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    difp_pkg::field_item_t out_reg,       out_next;

    // per-byte decode
    logic             accept;
    logic             emit;
    logic             closes;
    logic             is_start;
    logic             is_end;
    logic             is_sep;
    logic             is_digit;
    logic             take_digit;
    logic             last;
    logic [VW-1:0]    acc_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic             ovl_upd;
    logic [VW-1:0]    acc_times_ten;
    logic [NW:0]      fields_plus_one;

    // handshake: take a byte when the result register is free or draining
    assign text_in.ready   = !out_valid_reg || field_out.ready;
    assign accept          = text_in.valid && text_in.ready;
    assign field_out.valid = out_valid_reg;
    assign field_out.data  = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= difp_pkg::START_CHAR_RST;
            sep_char_reg   <= difp_pkg::SEP_CHAR_RST;
            end_char_reg   <= difp_pkg::END_CHAR_RST;
            max_fields_reg <= difp_pkg::MAX_FIELDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                difp_pkg::REG_START_CHAR: start_char_reg <= cfg_data;
                difp_pkg::REG_SEP_CHAR:   sep_char_reg   <= cfg_data;
                difp_pkg::REG_END_CHAR:   end_char_reg   <= cfg_data;
                difp_pkg::REG_MAX_FIELDS: max_fields_reg <= cfg_data;
                default:                  start_char_reg <= start_char_reg;
            endcase
        end
    end

    // byte classification
    always_comb
    begin
        is_start   = text_in.data.text_byte == start_char_reg;
        is_end     = text_in.data.text_byte == end_char_reg;
        is_sep     = text_in.data.text_byte == sep_char_reg;
        is_digit   = (text_in.data.text_byte >= difp_pkg::CHAR_ZERO)
                  && (text_in.data.text_byte <= difp_pkg::CHAR_NINE);
        take_digit = is_digit && !is_end && !is_sep;
    end

    // digit accumulation, value kept modulo 2^17
    always_comb
    begin
        acc_times_ten = {acc_reg[VW-4:0], 3'b000} + {acc_reg[VW-2:0], 1'b0};
        acc_upd       = acc_reg;
        cnt_upd       = digit_count_reg;
        ovl_upd       = overlong_reg;
        if (take_digit)
        begin
            if (digit_count_reg < CNT_W'(MAX_DIGITS))
            begin
                acc_upd = acc_times_ten + VW'(text_in.data.text_byte[3:0]);
                cnt_upd = digit_count_reg + CNT_W'(1);
            end
            else
            begin
                ovl_upd = 1'b1;
            end
        end
    end

    // frame control and result forming
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        acc_next         = acc_reg;
        digit_count_next = digit_count_reg;
        overlong_next    = overlong_reg;
        fields_done_next = fields_done_reg;
        emit             = 1'b0;
        closes           = 1'b0;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (is_start && !text_in.data.end_of_text)
                begin
                    in_frame_next    = 1'b1;
                    fields_done_next = '0;
                    acc_next         = '0;
                    digit_count_next = '0;
                    overlong_next    = 1'b0;
                end
            end
            else
            begin
                priority if (is_end)
                begin
                    emit   = 1'b1;
                    closes = 1'b1;
                end
                else if (is_sep)
                begin
                    emit   = 1'b1;
                    closes = text_in.data.end_of_text;
                end
                else
                begin
                    acc_next         = acc_upd;
                    digit_count_next = cnt_upd;
                    overlong_next    = ovl_upd;
                    emit             = text_in.data.end_of_text;
                    closes           = text_in.data.end_of_text;
                end
            end
        end

        // zero max_fields behaves as one
        fields_plus_one = {1'b0, fields_done_reg} + (NW+1)'(1);
        last            = closes || (fields_plus_one >= {1'b0, max_fields_reg});

        out_next.field_value  = ovl_upd ? '0 : acc_upd;
        out_next.field_number = fields_done_reg;
        out_next.too_long     = ovl_upd;
        out_next.last_field   = last;

        if (emit)
        begin
            acc_next         = '0;
            digit_count_next = '0;
            overlong_next    = 1'b0;
            if (last)
            begin
                in_frame_next    = 1'b0;
                fields_done_next = '0;
            end
            else
            begin
                fields_done_next = fields_plus_one[NW-1:0];
            end
        end

        // result register occupancy
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (field_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            acc_reg         <= '0;
            digit_count_reg <= '0;
            overlong_reg    <= 1'b0;
            fields_done_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            acc_reg         <= acc_next;
            digit_count_reg <= digit_count_next;
            overlong_reg    <= overlong_next;
            fields_done_reg <= fields_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    // checks
    `DIFP_ASSERT_IMP(a_hunt_clear, !in_frame_reg,
        (digit_count_reg == '0) && !overlong_reg && (fields_done_reg == '0),
        "field state not cleared while hunting")
    `DIFP_ASSERT_IMP(a_digit_bound, overlong_reg,
        digit_count_reg == CNT_W'(MAX_DIGITS),
        "overlong field without full digit count")
    `DIFP_ASSERT_NXT(a_last_closes, emit && last, !in_frame_reg,
        "frame still open after last field")
    `DIFP_ASSERT_IMP(a_no_overrun, field_out.valid && !field_out.ready,
        !text_in.ready,
        "byte taken while result register blocked")

endmodule

// ===== tb/sv/tb_delimited_integer_field_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_integer_field_parser
// drives framed text through the field parser with random bursts and stalls,
// predicts every field item in step with the parser and checks each result
// in order, across several delimiter and field limit settings
// ----------------------------------------------------------------------------
module tb_delimited_integer_field_parser;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 170;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    localparam logic [difp_pkg::BYTE_W-1:0] OPEN_B = difp_pkg::START_CHAR_RST;
    localparam logic [difp_pkg::BYTE_W-1:0] SEP_B  = difp_pkg::SEP_CHAR_RST;
    localparam logic [difp_pkg::BYTE_W-1:0] END_B  = difp_pkg::END_CHAR_RST;
    localparam logic [difp_pkg::BYTE_W-1:0] ZERO_B = difp_pkg::CHAR_ZERO;
    localparam logic [difp_pkg::BYTE_W-1:0] NINE_B = difp_pkg::CHAR_NINE;
    localparam difp_pkg::field_item_t       NO_FIELD = '0;

    // one row of the directed text
    typedef struct {
        logic [difp_pkg::BYTE_W-1:0] text;
        logic                        eot;
        bit                          known;
        difp_pkg::field_item_t       want;
    } text_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [difp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [difp_pkg::BYTE_W-1:0]    cfg_data;

    difp_stream_if #(.payload_t(difp_pkg::text_item_t))  text_if ();
    difp_stream_if #(.payload_t(difp_pkg::field_item_t)) field_if ();

    delimited_integer_field_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_in   (text_if),
        .field_out (field_if)
    );

    // mirror of the delimiter registers
    logic [difp_pkg::BYTE_W-1:0] start_byte;
    logic [difp_pkg::BYTE_W-1:0] sep_byte;
    logic [difp_pkg::BYTE_W-1:0] end_byte;
    logic [difp_pkg::BYTE_W-1:0] field_limit;

    // mirror of the parser state
    bit                            frame_open;
    int unsigned                   digit_sum;
    int unsigned                   digit_total;
    bit                            field_overflow;
    logic [difp_pkg::NUMBER_W-1:0] field_index;

    difp_pkg::field_item_t expected_fields [$];
    int                    framed_bytes;
    int                    mismatch_count;
    int                    burst_left;

    // directed text: hunting, start at end of text, extremes, overlong field,
    // empty field, start byte inside a frame, end of text on digit and separator
    text_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ZERO_B + 8'd1, 1'b0, 1'b1, NO_FIELD},
        '{OPEN_B,        1'b1, 1'b1, NO_FIELD},
        '{OPEN_B,        1'b0, 1'b1, NO_FIELD},
        '{NINE_B,        1'b0, 1'b1, NO_FIELD},
        '{NINE_B,        1'b0, 1'b1, NO_FIELD},
        '{NINE_B,        1'b0, 1'b1, NO_FIELD},
        '{NINE_B,        1'b0, 1'b1, NO_FIELD},
        '{NINE_B,        1'b0, 1'b1, NO_FIELD},
        '{SEP_B,         1'b0, 1'b1,
          difp_pkg::field_item_t'{17'd99999, 8'd0, 1'b0, 1'b0}},
        '{SEP_B,         1'b0, 1'b1, difp_pkg::field_item_t'{17'd0, 8'd1, 1'b0, 1'b0}},
        '{8'h00,         1'b0, 1'b1, NO_FIELD},
        '{OPEN_B,        1'b0, 1'b1, NO_FIELD},
        '{8'hFF,         1'b0, 1'b1, NO_FIELD},
        '{ZERO_B + 8'd1, 1'b0, 1'b0, NO_FIELD},
        '{ZERO_B + 8'd2, 1'b0, 1'b0, NO_FIELD},
        '{ZERO_B + 8'd3, 1'b0, 1'b0, NO_FIELD},
        '{ZERO_B + 8'd4, 1'b0, 1'b0, NO_FIELD},
        '{ZERO_B + 8'd5, 1'b0, 1'b0, NO_FIELD},
        '{ZERO_B + 8'd6, 1'b0, 1'b0, NO_FIELD},
        '{END_B,         1'b0, 1'b1, difp_pkg::field_item_t'{17'd0, 8'd2, 1'b1, 1'b1}},
        '{OPEN_B,        1'b0, 1'b1, NO_FIELD},
        '{ZERO_B,        1'b1, 1'b1, difp_pkg::field_item_t'{17'd0, 8'd0, 1'b0, 1'b1}},
        '{SEP_B,         1'b1, 1'b1, NO_FIELD},
        '{OPEN_B,        1'b0, 1'b1, NO_FIELD},
        '{SEP_B,         1'b1, 1'b1, difp_pkg::field_item_t'{17'd0, 8'd0, 1'b0, 1'b1}}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_digits();
        digit_sum      = 0;
        digit_total    = 0;
        field_overflow = 1'b0;
    endfunction

    function automatic void reset_parser_mirror();
        start_byte  = difp_pkg::START_CHAR_RST;
        sep_byte    = difp_pkg::SEP_CHAR_RST;
        end_byte    = difp_pkg::END_CHAR_RST;
        field_limit = difp_pkg::MAX_FIELDS_RST;
        frame_open  = 1'b0;
        field_index = '0;
        clear_digits();
    endfunction

    // build the field item and move on to the next field or back to hunting
    function automatic void close_field(input bit closes,
                                        output difp_pkg::field_item_t res);
        bit closing;
        closing = closes || (int'(field_index) + 1 >= int'(field_limit));
        res.field_value  = field_overflow ? '0 : digit_sum[difp_pkg::VALUE_W-1:0];
        res.field_number = field_index;
        res.too_long     = field_overflow;
        res.last_field   = closing;
        clear_digits();
        if (closing)
        begin
            frame_open  = 1'b0;
            field_index = '0;
        end
        else
        begin
            field_index = field_index + 1'b1;
        end
    endfunction

    // advance the parser mirror by one text byte, 1 when a field item results
    function automatic bit parse_text_byte(input logic [difp_pkg::BYTE_W-1:0] b,
                                           input logic eot,
                                           output difp_pkg::field_item_t res);
        res = '0;
        if (!frame_open)
        begin
            if (b == start_byte && !eot)
            begin
                frame_open  = 1'b1;
                field_index = '0;
                clear_digits();
                framed_bytes++;
            end
            return 1'b0;
        end
        framed_bytes++;
        // end character outranks separator, separator outranks digit
        if (b == end_byte)
        begin
            close_field(1'b1, res);
            return 1'b1;
        end
        if (b == sep_byte)
        begin
            close_field(eot, res);
            return 1'b1;
        end
        if (b >= difp_pkg::CHAR_ZERO && b <= difp_pkg::CHAR_NINE)
        begin
            if (digit_total < difp_pkg::MAX_DIGITS_DEF)
            begin
                digit_sum = digit_sum * 10 + (b - difp_pkg::CHAR_ZERO);
                digit_total++;
            end
            else
            begin
                field_overflow = 1'b1;
            end
        end
        if (eot)
        begin
            close_field(1'b1, res);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // hand one text byte over in bursts with random gaps between them
    task automatic send_text(input logic [difp_pkg::BYTE_W-1:0] b, input logic eot,
                             input bit known, input difp_pkg::field_item_t want);
        difp_pkg::field_item_t predicted;
        bit                    has_field;
        int                    gap_len;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0)
            begin
                text_if.valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        text_if.valid <= 1'b1;
        text_if.data  <= difp_pkg::text_item_t'{b, eot};
        do @(posedge clk); while (!text_if.ready);
        has_field = parse_text_byte(b, eot, predicted);
        if (known)
        begin
            if (want != NO_FIELD)
                expected_fields.push_back(want);
        end
        else if (has_field)
        begin
            expected_fields.push_back(predicted);
        end
        burst_left--;
    endtask

    // well-formed frame with random content, stray bytes and early end of text
    task automatic send_frame();
        int n_fields;
        int n_digits;
        int f;
        int d;
        send_text(start_byte, 1'b0, 1'b0, NO_FIELD);
        n_fields = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
        for (f = 0; f < n_fields && frame_open; f++)
        begin
            n_digits = ($urandom_range(0, 6) == 0) ? $urandom_range(6, 8)
                                                   : $urandom_range(0, 5);
            for (d = 0; d < n_digits && frame_open; d++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_text(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_FIELD);
                if (frame_open)
                    send_text(difp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)),
                              $urandom_range(0, 79) == 0, 1'b0, NO_FIELD);
            end
            if (frame_open && f < n_fields - 1)
                send_text(sep_byte, $urandom_range(0, 79) == 0, 1'b0, NO_FIELD);
        end
        // close whatever is still open
        if (frame_open)
        begin
            case ($urandom_range(0, 3))
                0, 1: send_text(end_byte, 1'b0, 1'b0, NO_FIELD);
                2:    send_text(sep_byte, 1'b1, 1'b0, NO_FIELD);
                default: send_text(difp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1,
                                   1'b0, NO_FIELD);
            endcase
        end
    endtask

    // frames separated by noise, with an optional full drain midway
    task automatic run_phase(input int target, input bit pause_midway);
        int  goal;
        bit  paused;
        goal   = framed_bytes + target;
        paused = 1'b0;
        while (framed_bytes < goal)
        begin
            repeat ($urandom_range(0, 3))
                send_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, NO_FIELD);
            if (pause_midway && !paused && framed_bytes >= goal - target / 2)
            begin
                text_if.valid <= 1'b0;
                while (expected_fields.size() != 0) @(posedge clk);
                @(posedge clk);
                paused = 1'b1;
            end
            send_frame();
        end
    endtask

    task automatic write_reg(input logic [difp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [difp_pkg::BYTE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            difp_pkg::REG_START_CHAR: start_byte  = val;
            difp_pkg::REG_SEP_CHAR:   sep_byte    = val;
            difp_pkg::REG_END_CHAR:   end_byte    = val;
            difp_pkg::REG_MAX_FIELDS: field_limit = val;
            default: ;
        endcase
    endtask

    // wait until the parser is idle, then load a new setting
    task automatic settle_and_configure(input logic [difp_pkg::BYTE_W-1:0] s,
                                        input logic [difp_pkg::BYTE_W-1:0] sp,
                                        input logic [difp_pkg::BYTE_W-1:0] e,
                                        input logic [difp_pkg::BYTE_W-1:0] m);
        text_if.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(difp_pkg::REG_START_CHAR, s);
        write_reg(difp_pkg::REG_SEP_CHAR, sp);
        write_reg(difp_pkg::REG_END_CHAR, e);
        write_reg(difp_pkg::REG_MAX_FIELDS, m);
        cfg_we <= 1'b0;
    endtask

    function automatic void note_mismatch(input string what,
                                          input difp_pkg::field_item_t want,
                                          input difp_pkg::field_item_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (%s) at %0t: expected value %0d number %0d",
                     what, $time, want.field_value, want.field_number,
                     " too_long %0b last %0b,", want.too_long, want.last_field,
                     " got value %0d number %0d too_long %0b last %0b",
                     got.field_value, got.field_number, got.too_long, got.last_field);
    endfunction

    // receiver stalls on an eight-bit pattern that is picked anew each time the tick counter wraps
    initial
    begin
        int         tick;
        logic [7:0] stall_map;
        field_if.ready <= 1'b0;
        tick      = 0;
        stall_map = 8'hFF;
        forever
        begin
            @(posedge clk);
            if (tick == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_map = 8'hFF;
                    1: stall_map = 8'($urandom_range(0, 255)) | 8'h01;
                    2: stall_map = 8'h55;
                    default: stall_map = 8'($urandom_range(0, 255)) | 8'h80;
                endcase
            end
            field_if.ready <= stall_map[3'(tick % 8)];
            tick = (tick + 1) % 48;
        end
    end

    // compare every accepted field item with the oldest prediction
    always @(posedge clk)
    begin
        difp_pkg::field_item_t want;
        if (rst_n && field_if.valid && field_if.ready)
        begin
            if (expected_fields.size() == 0)
            begin
                note_mismatch("unexpected item", NO_FIELD, field_if.data);
            end
            else
            begin
                want = expected_fields.pop_front();
                if (field_if.data.field_value  !== want.field_value  ||
                    field_if.data.field_number !== want.field_number ||
                    field_if.data.too_long     !== want.too_long     ||
                    field_if.data.last_field   !== want.last_field)
                    note_mismatch("field", want, field_if.data);
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        text_if.valid  = 1'b0;
        text_if.data   = '0;
        framed_bytes   = 0;
        mismatch_count = 0;
        burst_left     = 0;
        reset_parser_mirror();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text at the reset setting
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_text(directed_rows[r].text, directed_rows[r].eot, directed_rows[r].known,
                      directed_rows[r].want);

        // random frames across several settings, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: settle_and_configure(difp_pkg::START_CHAR_RST, difp_pkg::SEP_CHAR_RST,
                                        difp_pkg::END_CHAR_RST, 8'd3);
                1: settle_and_configure(8'h00, 8'hFF, 8'h0A, 8'd1);
                2: settle_and_configure(8'hFF, 8'h00, 8'h7F, 8'd255);
                3: settle_and_configure(difp_pkg::START_CHAR_RST, difp_pkg::SEP_CHAR_RST,
                                        difp_pkg::END_CHAR_RST, 8'd0);
                default: settle_and_configure(8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255)),
                                              ($urandom_range(0, 3) == 0)
                                                  ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(1, 8)));
            endcase
            run_phase(PHASE_BYTES, p == 0);
        end

        // drain and finish
        text_if.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
